### src/izvt_pkg.sv
package izvt_pkg;

  localparam int unsigned ZONES  = 4;
  localparam int unsigned ZIDX_W = (ZONES > 1) ? $clog2(ZONES) : 1;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_ZONE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TIME  = 1'b1;

  localparam logic [2:0] PRESSURE_ZONE_RST = 3'd0;
  localparam logic [7:0] RELEASE_TIME_RST  = 8'd20;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_ON     = 2'd1,
    KIND_OFF    = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  zone;
    logic [15:0] seconds;
    logic [7:0]  elapsed;
  } in_word_t;

  typedef struct packed {
    logic        status_code;
    logic [2:0]  zone_index;
    logic [15:0] seconds_left;
    logic [7:0]  forced_off_mask;
    logic [7:0]  valve_mask;
    logic        master_open;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic              apply;
    logic [ZIDX_W-1:0] stat_idx;
  } core_ctrl_t;

endpackage

### src/izvt_core.sv
module izvt_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [izvt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [izvt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  izvt_pkg::core_ctrl_t                ctrl_i,
  input  izvt_pkg::in_word_t                  word_i,
  output izvt_pkg::out_word_t                 res_o
);

  logic [15:0]                   time_q [izvt_pkg::ZONES];
  logic [15:0]                   time_d [izvt_pkg::ZONES];
  logic [izvt_pkg::ZONES-1:0]    valve_q, valve_d;
  logic                          master_q, master_d;
  logic signed [8:0]             rc_q, rc_d;
  logic [2:0]                    pz_q;
  logic [7:0]                    rt_q;

  // tick path
  logic signed [9:0]             rc_sub;
  logic signed [8:0]             rc_tick;
  logic [15:0]                   tick_time [izvt_pkg::ZONES];
  logic [izvt_pkg::ZONES-1:0]    tick_valve;
  logic                          tick_master;
  logic signed [8:0]             tick_rc;
  logic                          any_run;

  logic                          zone_ok;
  logic [izvt_pkg::ZIDX_W-1:0]   zsel;
  logic [7:0]                    forced;

  always_comb begin
    rc_sub  = {rc_q[8], rc_q} - $signed({2'b00, word_i.elapsed});
    rc_tick = (rc_sub < -10'sd1) ? -9'sd1 : rc_sub[8:0];
    any_run = 1'b0;
    for (int i = 0; i < int'(izvt_pkg::ZONES); i++) begin
      tick_time[i] = (time_q[i] > {8'd0, word_i.elapsed}) ?
                     time_q[i] - {8'd0, word_i.elapsed} : 16'd0;
      tick_valve[i] = valve_q[i];
      // pressure zone stays open while the release is running
      if (tick_time[i] == 16'd0 && valve_q[i] && (rc_tick[8] || pz_q != 3'(i))) begin
        tick_valve[i] = 1'b0;
      end
      if (tick_time[i] != 16'd0) begin
        tick_valve[i] = 1'b1;
        any_run       = 1'b1;
      end
    end
    tick_rc     = any_run ? 9'sd0 : rc_tick;
    tick_master = master_q;
    if (any_run) begin
      tick_master = 1'b1;
    end else if (master_q) begin
      tick_master = 1'b0;
      tick_rc     = $signed({1'b0, rt_q});
      for (int i = 0; i < int'(izvt_pkg::ZONES); i++) begin
        if (pz_q == 3'(i)) begin
          tick_valve[i] = 1'b1;
        end
      end
    end
  end

  assign zone_ok = {1'b0, word_i.zone} < 4'(izvt_pkg::ZONES);
  assign zsel    = word_i.zone[izvt_pkg::ZIDX_W-1:0];

  always_comb begin
    forced = 8'd0;
    for (int j = 0; j < int'(izvt_pkg::ZONES); j++) begin
      forced[j] = (3'(j) != word_i.zone) && (time_q[j] != 16'd0);
    end
  end

  // next state
  always_comb begin
    time_d   = time_q;
    valve_d  = valve_q;
    master_d = master_q;
    rc_d     = rc_q;
    case (izvt_pkg::kind_e'(word_i.kind))
      izvt_pkg::KIND_TICK: begin
        time_d   = tick_time;
        valve_d  = tick_valve;
        master_d = tick_master;
        rc_d     = tick_rc;
      end
      izvt_pkg::KIND_ON: begin
        if (zone_ok) begin
          for (int j = 0; j < int'(izvt_pkg::ZONES); j++) begin
            if (forced[j]) begin
              time_d[j] = 16'd0;
            end
          end
          time_d[zsel] = word_i.seconds;
        end
      end
      izvt_pkg::KIND_OFF: begin
        if (zone_ok) begin
          time_d[zsel] = 16'd0;
        end
      end
      default: ;
    endcase
  end

  // result word
  always_comb begin
    res_o                 = '0;
    res_o.status_code     = izvt_pkg::STATUS_OK;
    res_o.valve_mask      = 8'(valve_q);
    res_o.master_open     = master_q;
    res_o.last            = 1'b1;
    case (izvt_pkg::kind_e'(word_i.kind))
      izvt_pkg::KIND_TICK: begin
        res_o.valve_mask  = 8'(tick_valve);
        res_o.master_open = tick_master;
      end
      izvt_pkg::KIND_STATUS: begin
        res_o.zone_index   = 3'(ctrl_i.stat_idx);
        res_o.seconds_left = time_q[ctrl_i.stat_idx];
        res_o.last         = ctrl_i.stat_idx == izvt_pkg::ZIDX_W'(izvt_pkg::ZONES - 1);
      end
      izvt_pkg::KIND_ON, izvt_pkg::KIND_OFF: begin
        res_o.zone_index = word_i.zone;
        if (!zone_ok) begin
          res_o.status_code = izvt_pkg::STATUS_NOT_FOUND;
        end else if (word_i.kind == izvt_pkg::KIND_ON) begin
          res_o.seconds_left    = word_i.seconds;
          res_o.forced_off_mask = forced;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(izvt_pkg::ZONES); i++) begin
        time_q[i] <= 16'd0;
      end
      valve_q  <= '0;
      master_q <= 1'b0;
      rc_q     <= -9'sd1;
      pz_q     <= izvt_pkg::PRESSURE_ZONE_RST;
      rt_q     <= izvt_pkg::RELEASE_TIME_RST;
    end else begin
      if (ctrl_i.apply) begin
        time_q   <= time_d;
        valve_q  <= valve_d;
        master_q <= master_d;
        rc_q     <= rc_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          izvt_pkg::CFG_PRESSURE_ZONE: pz_q <= cfg_data_i[2:0];
          izvt_pkg::CFG_RELEASE_TIME:  rt_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### src/irrigation_zone_valve_timer_unit.sv
// Both the input word and its result word are registered.
// Throughput: one word per cycle for tick, on and off unless the output stalls;
// a status query holds the input register until one result per zone is out.
// A stalled output holds the input register; an empty input register still
// takes a word while a result waits. Reset: all zones stopped, valves closed,
// release idle, pressure zone 0, release time 20.
module irrigation_zone_valve_timer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [izvt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [izvt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  izvt_pkg::in_word_t                  in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output izvt_pkg::out_word_t                 out_word_o
);

  izvt_pkg::in_word_t            in_q;
  logic                          in_v_q;
  logic [izvt_pkg::ZIDX_W-1:0]   idx_q;
  izvt_pkg::out_word_t           out_q;
  logic                          out_v_q;

  logic                          advance;
  logic                          item_done;
  izvt_pkg::core_ctrl_t          ctrl;
  izvt_pkg::out_word_t           res;

  assign advance   = in_v_q && (!out_v_q || out_ready_i);
  assign item_done = (in_q.kind != izvt_pkg::KIND_STATUS) ||
                     (idx_q == izvt_pkg::ZIDX_W'(izvt_pkg::ZONES - 1));
  assign in_ready_o = !in_v_q || (advance && item_done);

  assign ctrl.apply    = advance && item_done;
  assign ctrl.stat_idx = idx_q;

  izvt_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (ctrl),
    .word_i     (in_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (in_ready_o) begin
        in_v_q <= in_valid_i;
      end
      if (advance) begin
        idx_q <= item_done ? '0 : idx_q + 1'b1;
      end
      out_v_q <= advance || (out_v_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_word_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

endmodule

### test/valve_timer_checker.sv
module valve_timer_checker
  import izvt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_word_t              in_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_word_t             out_word_i,
  output int unsigned           pending_o,
  output int unsigned           fail_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // mirrored block state
  logic [15:0] run_secs [ZONES];
  logic [7:0]  valves;
  logic        master;
  int          release_left;
  logic [2:0]  relief_zone;
  logic [7:0]  relief_secs;

  out_word_t   awaited_results [$];

  function automatic out_word_t result_word(logic st, logic [2:0] zi, logic [15:0] secs,
                                            logic [7:0] forced, logic fin);
    out_word_t r;
    r.status_code     = st;
    r.zone_index      = zi;
    r.seconds_left    = secs;
    r.forced_off_mask = forced;
    r.valve_mask      = valves;
    r.master_open     = master;
    r.last            = fin;
    return r;
  endfunction

  task automatic queue_result(input out_word_t w);
    awaited_results = {awaited_results, w};
  endtask

  task automatic run_tick(input logic [7:0] elapsed);
    logic any_running;
    any_running = 1'b0;
    release_left = release_left - int'(elapsed);
    if (release_left < -1) release_left = -1;
    for (int i = 0; i < ZONES; i++) begin
      run_secs[i] = (run_secs[i] > 16'(elapsed)) ? run_secs[i] - 16'(elapsed) : 16'd0;
      // expired zones close, except the relief zone while release runs
      if (run_secs[i] == 0 && valves[i] && (release_left < 0 || int'(relief_zone) != i))
        valves[i] = 1'b0;
    end
    for (int i = 0; i < ZONES; i++) begin
      if (run_secs[i] != 0) begin
        any_running = 1'b1;
        release_left = 0;
        valves[i] = 1'b1;
      end
    end
    if (any_running) begin
      master = 1'b1;
    end else if (master) begin
      master = 1'b0;
      release_left = int'(relief_secs);
      if (int'(relief_zone) < ZONES) valves[relief_zone] = 1'b1;
    end
  endtask

  task automatic apply_command(input in_word_t w);
    logic [7:0] forced;
    forced = '0;
    case (kind_e'(w.kind))
      KIND_TICK: begin
        run_tick(w.elapsed);
        queue_result(result_word(STATUS_OK, 3'd0, 16'd0, 8'd0, 1'b1));
      end
      KIND_STATUS: begin
        for (int j = 0; j < ZONES; j++)
          queue_result(result_word(STATUS_OK, 3'(j), run_secs[j], 8'd0, j == ZONES - 1));
      end
      default: begin
        if (int'(w.zone) >= ZONES) begin
          queue_result(result_word(STATUS_NOT_FOUND, w.zone, 16'd0, 8'd0, 1'b1));
        end else if (kind_e'(w.kind) == KIND_ON) begin
          for (int j = 0; j < ZONES; j++) begin
            if (j != int'(w.zone) && run_secs[j] != 0) begin
              run_secs[j] = 16'd0;
              forced[j] = 1'b1;
            end
          end
          run_secs[w.zone] = w.seconds;
          queue_result(result_word(STATUS_OK, w.zone, w.seconds, forced, 1'b1));
        end else begin
          run_secs[w.zone] = 16'd0;
          queue_result(result_word(STATUS_OK, w.zone, 16'd0, 8'd0, 1'b1));
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (awaited_results.size() == 0) begin
      $error("result word with nothing pending: %h", got);
      fail_count_o++;
    end else begin
      want = awaited_results.pop_front();
      check_field("status_code", want.status_code, got.status_code);
      check_field("zone_index", want.zone_index, got.zone_index);
      check_field("seconds_left", want.seconds_left, got.seconds_left);
      check_field("forced_off_mask", want.forced_off_mask, got.forced_off_mask);
      check_field("valve_mask", want.valve_mask, got.valve_mask);
      check_field("master_open", want.master_open, got.master_open);
      check_field("last", want.last, got.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ZONES; i++) run_secs[i] = 16'd0;
      valves       = '0;
      master       = 1'b0;
      release_left = -1;
      relief_zone  = PRESSURE_ZONE_RST;
      relief_secs  = RELEASE_TIME_RST;
      awaited_results.delete();
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_word_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_PRESSURE_ZONE) relief_zone = cfg_data_i[2:0];
        else if (cfg_idx_i == CFG_RELEASE_TIME) relief_secs = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) apply_command(in_word_i);
      pending_o <= awaited_results.size();
    end
  end

endmodule

### test/tb_top.sv
module tb_top;
  import izvt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 4000;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_word_t              in_word_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_word_t             out_word_o;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;

  irrigation_zone_valve_timer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  valve_timer_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_word_i    (in_word_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_i   (out_word_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_gap_pct);

  // watchdog: cycles with no word moving on any port
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic in_word_t make_cmd(kind_e k, logic [2:0] z, logic [15:0] s, logic [7:0] e);
    in_word_t w;
    w.kind    = k;
    w.zone    = z;
    w.seconds = s;
    w.elapsed = e;
    return w;
  endfunction

  // mostly short watering runs so zones expire and the relief phase gets exercised
  function automatic in_word_t random_cmd();
    in_word_t    w;
    int unsigned r;
    w.kind    = KIND_TICK;
    w.zone    = 3'($urandom_range(7));
    w.seconds = 16'($urandom_range(16'hFFFF));
    w.elapsed = 8'($urandom_range(255));
    r = $urandom_range(99);
    if (r < 45) begin
      if ($urandom_range(9) != 0) w.elapsed = 8'($urandom_range(12));
    end else if (r < 70) begin
      w.kind = KIND_ON;
      if ($urandom_range(9) != 0) w.zone = 3'($urandom_range(ZONES - 1));
      r = $urandom_range(9);
      if (r < 7) w.seconds = 16'($urandom_range(1, 40));
      else if (r == 7) w.seconds = 16'd0;
    end else if (r < 82) begin
      w.kind = KIND_OFF;
      if ($urandom_range(9) != 0) w.zone = 3'($urandom_range(ZONES - 1));
    end else begin
      w.kind = KIND_STATUS;
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // stop sending and wait until every pending result is out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [2:0] zone, input logic [7:0] secs);
    drain();
    // upper data bits are don't-care for the zone register
    write_reg(CFG_PRESSURE_ZONE, {5'($urandom_range(31)), zone});
    write_reg(CFG_RELEASE_TIME, secs);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      send_word(random_cmd());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset config, one full water-then-relieve cycle
    send_word(make_cmd(KIND_STATUS, 3'd0, 16'd0, 8'd0));
    send_word(make_cmd(KIND_TICK, 3'd7, 16'hFFFF, 8'd0));
    send_word(make_cmd(KIND_ON, 3'd1, 16'd10, 8'hFF));
    send_word(make_cmd(KIND_ON, 3'd2, 16'hFFFF, 8'd0));
    send_word(make_cmd(KIND_OFF, 3'd7, 16'd0, 8'd0));
    send_word(make_cmd(KIND_ON, 3'(ZONES), 16'd5, 8'd0));
    send_word(make_cmd(KIND_ON, 3'd7, 16'hFFFF, 8'hFF));
    send_word(make_cmd(KIND_TICK, 3'd0, 16'd0, 8'd0));
    send_word(make_cmd(KIND_STATUS, 3'd5, 16'h5555, 8'hAA));
    send_word(make_cmd(KIND_ON, 3'd3, 16'd3, 8'd0));
    send_word(make_cmd(KIND_TICK, 3'd0, 16'd0, 8'd1));
    send_word(make_cmd(KIND_TICK, 3'd0, 16'd0, 8'hFF));
    send_word(make_cmd(KIND_TICK, 3'd0, 16'd0, 8'd5));
    send_word(make_cmd(KIND_STATUS, 3'd0, 16'd0, 8'd0));
    send_word(make_cmd(KIND_TICK, 3'd0, 16'd0, 8'hFF));
    send_word(make_cmd(KIND_ON, 3'd0, 16'd1, 8'd0));
    send_word(make_cmd(KIND_TICK, 3'd0, 16'd0, 8'd1));
    send_word(make_cmd(KIND_ON, 3'd0, 16'd0, 8'd0));
    send_word(make_cmd(KIND_ON, 3'd3, 16'hFFFF, 8'd0));
    send_word(make_cmd(KIND_TICK, 3'd0, 16'd0, 8'hFF));
    send_word(make_cmd(KIND_OFF, 3'd3, 16'd0, 8'd0));
    send_word(make_cmd(KIND_OFF, 3'd0, 16'hFFFF, 8'hFF));
    send_word(make_cmd(KIND_TICK, 3'd0, 16'd0, 8'd0));
    send_word(make_cmd(KIND_STATUS, 3'd0, 16'd0, 8'd0));

    configure(3'(ZONES - 1), 8'd0);
    send_gap_pct = 26;
    recv_gap_pct = 52;
    random_phase(50);

    configure(3'd7, 8'hFF);
    send_gap_pct = 52;
    recv_gap_pct = 26;
    random_phase(50);

    configure(3'($urandom_range(7)), 8'($urandom_range(1, 60)));
    send_gap_pct = 0;
    recv_gap_pct = 0;
    random_phase(50);

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
